// File: rtl/lorentz_boost_momentum_defines.svh
// assertion macros for the lorentz boost block
// used by rtl files that assert; expects clk and rst_n in scope
`ifndef LORENTZ_BOOST_MOMENTUM_DEFINES_SVH
`define LORENTZ_BOOST_MOMENTUM_DEFINES_SVH

// same-cycle implication, off during reset
`define LBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lbm_pkg.sv
// types, constants and stage map for the lorentz boost pipeline
// no dependencies
`timescale 1ns / 1ps

package lbm_pkg;

  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic [30:0]        energy;
    logic signed [31:0] beta_x;
    logic signed [31:0] beta_y;
    logic signed [31:0] beta_z;
  } lbm_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               invalid;
  } lbm_out_t;

  // per-request context carried down the pipeline
  typedef struct packed {
    lbm_in_t            inp;
    logic               inv;
    logic               pass;
    logic signed [63:0] pdb;
    logic [60:0]        g;
    logic [60:0]        f;
    logic signed [63:0] k;
  } lbm_ctx_t;

  localparam logic [63:0] MAG_LIM = 64'h2000_0000_0000_0000;
  localparam logic [63:0] ONE2    = 64'h1000_0000_0000_0000;
  localparam logic [60:0] ONE1    = 61'h4000_0000;

  // product shifts
  localparam int PDB_SH = 14;
  localparam int FK_SH  = 30;
  localparam int GE_SH  = 14;
  localparam int DEL_SH = 46;

  // stage map
  localparam int SQ_N   = 31;
  localparam int D1_N   = 61;
  localparam int D2_N   = 30;
  localparam int T_FLAG = 3;
  localparam int T_PDB  = 4;
  localparam int T_D1   = T_FLAG + SQ_N;
  localparam int T_G    = T_D1 + D1_N;
  localparam int T_F    = T_G + D2_N;
  localparam int T_K    = T_F + 4;
  localparam int T_OUT  = T_K + 4;

endpackage

// File: rtl/lbm_mul.sv
// three-stage signed product from 64-bit magnitudes: shift, limit to 2^61
// depends on lbm_pkg
`timescale 1ns / 1ps

module lbm_mul #(
  parameter int SH = 0
) (
  input  logic               clk,
  input  logic [63:0]        a_mag,
  input  logic [63:0]        b_mag,
  input  logic               neg,
  output logic signed [63:0] prod
);
  import lbm_pkg::*;

  logic [63:0]        p00_r, p01_r, p10_r, p11_r;
  logic               neg1_r, neg2_r;
  logic [127:0]       full_r;
  logic [127:0]       shr;
  logic [63:0]        lim_mag;
  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    p00_r  <= a_mag[31:0]  * b_mag[31:0];
    p01_r  <= a_mag[31:0]  * b_mag[63:32];
    p10_r  <= a_mag[63:32] * b_mag[31:0];
    p11_r  <= a_mag[63:32] * b_mag[63:32];
    neg1_r <= neg;
  end

  always_ff @(posedge clk) begin
    full_r <= {64'b0, p00_r} + ({64'b0, p01_r} << 32) + ({64'b0, p10_r} << 32)
              + {p11_r, 64'b0};
    neg2_r <= neg1_r;
  end

  always_comb begin
    shr     = full_r >> SH;
    lim_mag = (shr > {64'b0, MAG_LIM}) ? MAG_LIM : shr[63:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= neg2_r ? -$signed(lim_mag) : $signed(lim_mag);
  end

  assign prod = prod_r;

endmodule

// File: rtl/lorentz_boost_momentum.sv
// lorentz boost of a 3-momentum, fully pipelined
// depends on lbm_pkg, lbm_mul and lorentz_boost_momentum_defines.svh
//
//  channel | ports                        | handshake
//  input   | start, busy, in_data         | taken when start and not busy
//  result  | out_strobe, out_data         | one cycle, no backpressure
//  config  | cfg_valid, cfg_ready, cfg_data | write when valid and ready
//
// one request per clock
// pipeline depth is set by the bit-per-stage square root (31) and the two
// restoring dividers (61 and 30 stages) that form gamma and (gamma-1)/bsq
// busy never rises; cfg_ready is always high
// reset clears the valid chain and sets min_beta_sq to 1
`timescale 1ns / 1ps
`include "lorentz_boost_momentum_defines.svh"

module lorentz_boost_momentum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lbm_pkg::lbm_in_t in_data,
  output logic             out_strobe,
  output lbm_pkg::lbm_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [30:0]      cfg_data
);
  import lbm_pkg::*;

  localparam logic signed [63:0] LIM_S = 64'sh2000_0000_0000_0000;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] lim(input logic signed [63:0] v);
    if (v > LIM_S) return LIM_S;
    if (v < -LIM_S) return -LIM_S;
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic [30:0]     min_bsq_r;
  logic [T_OUT:0]  vld_r;
  lbm_ctx_t        ctx_r [T_OUT];
  lbm_ctx_t        ctx0_nxt;
  lbm_out_t        out_r;
  logic            accept;

  logic [63:0]     sq_r [3];
  logic [63:0]     bsq_r;

  logic [60:0]     sq_x_r  [SQ_N];
  logic [30:0]     sq_rt_r [SQ_N];
  logic [30:0]     d1_rem_r [D1_N];
  logic [60:0]     d1_q_r   [D1_N];
  logic [30:0]     d1_dv_r  [D1_N];
  logic [61:0]     d2_rem_r [D2_N];
  logic [29:0]     d2_q_r   [D2_N];
  logic [61:0]     d2_dv_r  [D2_N];

  logic signed [31:0] mom0 [3];
  logic signed [31:0] beta0 [3];
  logic signed [31:0] betak [3];
  logic signed [63:0] pdb_p [3];
  logic signed [63:0] del_p [3];
  logic signed [63:0] fk_p, ge_p;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_bsq_r <= 31'd1;
    end else if (cfg_valid && cfg_ready) begin
      min_bsq_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T_OUT-1:0], accept};
    end
  end

  // stage 0 captures the request
  always_comb begin
    ctx0_nxt     = '0;
    ctx0_nxt.inp = in_data;
  end

  always_ff @(posedge clk) begin
    ctx_r[0] <= ctx0_nxt;
  end

  assign mom0[0]  = ctx_r[0].inp.mom_x;
  assign mom0[1]  = ctx_r[0].inp.mom_y;
  assign mom0[2]  = ctx_r[0].inp.mom_z;
  assign beta0[0] = ctx_r[0].inp.beta_x;
  assign beta0[1] = ctx_r[0].inp.beta_y;
  assign beta0[2] = ctx_r[0].inp.beta_z;
  assign betak[0] = ctx_r[T_K].inp.beta_x;
  assign betak[1] = ctx_r[T_K].inp.beta_y;
  assign betak[2] = ctx_r[T_K].inp.beta_z;

  // beta squared, exact in 64 bits
  for (genvar i = 0; i < 3; i++) begin : g_sq
    logic [31:0] bmag;
    assign bmag = 32'(mag64(64'(beta0[i])));
    always_ff @(posedge clk) begin
      sq_r[i] <= 64'(bmag) * 64'(bmag);
    end
  end

  always_ff @(posedge clk) begin
    bsq_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  for (genvar i = 0; i < 3; i++) begin : g_pdb
    lbm_mul #(.SH(PDB_SH)) u_mul (
      .clk   (clk),
      .a_mag (mag64(64'(mom0[i]))),
      .b_mag (mag64(64'(beta0[i]))),
      .neg   (mom0[i][31] ^ beta0[i][31]),
      .prod  (pdb_p[i])
    );
  end

  // floor square root, one root bit per stage
  for (genvar n = 0; n < SQ_N; n++) begin : g_sqrt
    localparam int J = SQ_N - 1 - n;
    logic [60:0] x_in;
    logic [30:0] rt_in;
    logic [63:0] add;
    if (n == 0) begin : g_init
      assign x_in  = 61'(ONE2 - bsq_r);
      assign rt_in = '0;
    end else begin : g_chain
      assign x_in  = sq_x_r[n-1];
      assign rt_in = sq_rt_r[n-1];
    end
    always_comb begin
      add = (64'(rt_in) << (J + 1)) + (64'd1 << (2 * J));
    end
    always_ff @(posedge clk) begin
      if ({3'b0, x_in} >= add) begin
        sq_x_r[n]  <= 61'({3'b0, x_in} - add);
        sq_rt_r[n] <= rt_in | (31'd1 << J);
      end else begin
        sq_x_r[n]  <= x_in;
        sq_rt_r[n] <= rt_in;
      end
    end
  end

  // gamma = 2^60 / s, one quotient bit per stage
  for (genvar m = 0; m < D1_N; m++) begin : g_div1
    localparam int I = D1_N - 1 - m;
    localparam logic DB = (m == 0);
    logic [30:0] rem_in;
    logic [60:0] q_in;
    logic [30:0] dv_in;
    logic [30:0] rem2;
    if (m == 0) begin : g_init
      assign rem_in = '0;
      assign q_in   = '0;
      assign dv_in  = (sq_rt_r[SQ_N-1] == '0) ? 31'd1 : sq_rt_r[SQ_N-1];
    end else begin : g_chain
      assign rem_in = d1_rem_r[m-1];
      assign q_in   = d1_q_r[m-1];
      assign dv_in  = d1_dv_r[m-1];
    end
    assign rem2 = {rem_in[29:0], DB};
    always_ff @(posedge clk) begin
      d1_dv_r[m] <= dv_in;
      if (rem2 >= dv_in) begin
        d1_rem_r[m] <= rem2 - dv_in;
        d1_q_r[m]   <= q_in | (61'd1 << I);
      end else begin
        d1_rem_r[m] <= rem2;
        d1_q_r[m]   <= q_in;
      end
    end
  end

  // 2^60 / (gamma + 1); the upper quotient bits are known zero
  for (genvar m = 0; m < D2_N; m++) begin : g_div2
    localparam int I = D2_N - 1 - m;
    logic [61:0] rem_in;
    logic [29:0] q_in;
    logic [61:0] dv_in;
    logic [62:0] rem2;
    if (m == 0) begin : g_init
      assign rem_in = 62'(ONE1);
      assign q_in   = '0;
      assign dv_in  = 62'(d1_q_r[D1_N-1]) + 62'(ONE1);
    end else begin : g_chain
      assign rem_in = d2_rem_r[m-1];
      assign q_in   = d2_q_r[m-1];
      assign dv_in  = d2_dv_r[m-1];
    end
    assign rem2 = {rem_in, 1'b0};
    always_ff @(posedge clk) begin
      d2_dv_r[m] <= dv_in;
      if (rem2 >= {1'b0, dv_in}) begin
        d2_rem_r[m] <= 62'(rem2 - {1'b0, dv_in});
        d2_q_r[m]   <= q_in | (30'd1 << I);
      end else begin
        d2_rem_r[m] <= rem2[61:0];
        d2_q_r[m]   <= q_in;
      end
    end
  end

  lbm_mul #(.SH(FK_SH)) u_fk (
    .clk   (clk),
    .a_mag ({3'b0, ctx_r[T_F].f}),
    .b_mag (mag64(ctx_r[T_F].pdb)),
    .neg   (ctx_r[T_F].pdb[63]),
    .prod  (fk_p)
  );

  lbm_mul #(.SH(GE_SH)) u_ge (
    .clk   (clk),
    .a_mag ({3'b0, ctx_r[T_F].g}),
    .b_mag ({33'b0, ctx_r[T_F].inp.energy}),
    .neg   (1'b0),
    .prod  (ge_p)
  );

  for (genvar i = 0; i < 3; i++) begin : g_del
    lbm_mul #(.SH(DEL_SH)) u_mul (
      .clk   (clk),
      .a_mag (mag64(64'(betak[i]))),
      .b_mag (mag64(ctx_r[T_K].k)),
      .neg   (betak[i][31] ^ ctx_r[T_K].k[63]),
      .prod  (del_p[i])
    );
  end

  // context chain with per-stage updates
  for (genvar j = 1; j < T_OUT; j++) begin : g_ctx
    lbm_ctx_t ctx_nxt;
    always_comb begin
      ctx_nxt = ctx_r[j-1];
      if (j == T_FLAG) begin
        ctx_nxt.inv  = bsq_r >= ONE2;
        ctx_nxt.pass = bsq_r < {3'b0, min_bsq_r, 30'b0};
      end
      if (j == T_PDB) begin
        ctx_nxt.pdb = pdb_p[0] + pdb_p[1] + pdb_p[2];
      end
      if (j == T_G) begin
        ctx_nxt.g = d1_q_r[D1_N-1];
      end
      if (j == T_F) begin
        ctx_nxt.f = ctx_r[j-1].g + 61'(d2_q_r[D2_N-1]) - ONE1;
      end
      if (j == T_K) begin
        ctx_nxt.k = lim(fk_p - ge_p);
      end
    end
    always_ff @(posedge clk) begin
      ctx_r[j] <= ctx_nxt;
    end
  end

  // output stage: passthrough when invalid or below threshold
  always_ff @(posedge clk) begin
    out_r.invalid <= ctx_r[T_OUT-1].inv;
    if (ctx_r[T_OUT-1].inv || ctx_r[T_OUT-1].pass) begin
      out_r.out_x <= ctx_r[T_OUT-1].inp.mom_x;
      out_r.out_y <= ctx_r[T_OUT-1].inp.mom_y;
      out_r.out_z <= ctx_r[T_OUT-1].inp.mom_z;
    end else begin
      out_r.out_x <= sat32(64'(ctx_r[T_OUT-1].inp.mom_x) + del_p[0]);
      out_r.out_y <= sat32(64'(ctx_r[T_OUT-1].inp.mom_y) + del_p[1]);
      out_r.out_z <= sat32(64'(ctx_r[T_OUT-1].inp.mom_z) + del_p[2]);
    end
  end

  assign out_strobe = vld_r[T_OUT];
  assign out_data   = out_r;

  `LBM_ASSERT_IMP(a_latency, start && !busy, ##(T_OUT + 1) out_strobe, "request lost in pipeline")
  `LBM_ASSERT_IMP(a_inv_pass, out_strobe && out_data.invalid, out_data.out_x == $past(ctx_r[T_OUT-1].inp.mom_x), "invalid result not passthrough")
  `LBM_ASSERT_NXT(a_gamma, vld_r[T_G-1] && !ctx_r[T_G-1].inv, ctx_r[T_G].g >= ONE1, "gamma below one")

endmodule
